[rtl/assert_macros.svh]
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// checked at every rising clock edge while out of reset
`define BSFR_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("%m: check failed");
// checked at every rising clock edge, reset included
`define BSFR_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("%m: check failed");
`else
`define BSFR_ASSERT(lbl, clk, rstn, prop)
`define BSFR_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

[rtl/bsfr_pkg.sv]
// shared types and constants of the byte stream frame receiver
`default_nettype none

package bsfr_pkg;

  // frame layout: 2 start bytes, 6 header bytes, payload, 2 crc bytes, 2 end bytes
  localparam int unsigned StartLen      = 2;
  localparam int unsigned PayloadStart  = 8;
  localparam int unsigned FrameOverhead = 12;
  localparam int unsigned CmdSlots      = 32;

  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'h1021;

  // configuration register indexes
  localparam logic [1:0] RegStartPattern = 2'd0;
  localparam logic [1:0] RegEndPattern   = 2'd1;
  localparam logic [1:0] RegHandlerMask  = 2'd2;

  localparam logic [15:0] StartPatternRst = 16'hAA55;
  localparam logic [15:0] EndPatternRst   = 16'h55AA;

  typedef enum logic [2:0] {
    ST_DELIVERED  = 3'd0,
    ST_LEN_BIG    = 3'd1,
    ST_CRC_BAD    = 3'd2,
    ST_END_BAD    = 3'd3,
    ST_NO_HANDLER = 3'd4,
    ST_OVERFLOW   = 3'd5
  } status_e;

  // frame report handed from the deframer to the output side
  typedef struct packed {
    status_e     status;
    logic [7:0]  src;
    logic [7:0]  dst;
    logic [7:0]  cmd;
    logic [7:0]  flags;
    logic [15:0] plen;
    logic        deliver;
  } rpt_t;

endpackage

`default_nettype wire

[rtl/bsfr_deframer.sv]
// start hunt, header capture, running crc and frame checks
`default_nettype none
`include "assert_macros.svh"

module bsfr_deframer import bsfr_pkg::*; #(
  parameter int unsigned MAX_PAYLOAD = 64,
  localparam int unsigned AddrW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    byte_valid_i,
  input  wire logic [7:0]              byte_i,
  input  wire logic [15:0]             start_pattern_i,
  input  wire logic [15:0]             end_pattern_i,
  input  wire logic [31:0]             handler_mask_i,
  output logic                         wr_en_o,
  output logic [AddrW-1:0]             wr_addr_o,
  output logic [7:0]                   wr_data_o,
  output logic                         rpt_valid_o,
  output rpt_t                         rpt_o
);

  localparam int unsigned StoreDepth = FrameOverhead + MAX_PAYLOAD;
  localparam int unsigned CntW       = $clog2(StoreDepth + 1);

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ((c << 1) ^ CrcPoly) : (c << 1);
    end
    return c;
  endfunction

  logic            in_frame_q, in_frame_d;
  logic            have_q, have_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [7:0]      prev_q;
  logic [7:0]      src_q, dst_q, cmd_q, flags_q, len_hi_q, len_lo_q;
  logic [7:0]      t0_q, t1_q, t2_q;
  logic [15:0]     crc_q;

  logic [CntW-1:0] cnt_n, off;
  logic [15:0]     len, exp_cnt;
  logic            done, full, crc_take, start_hit;
  status_e         status;

  always_comb begin
    cnt_n     = cnt_q + 1'b1;
    off       = cnt_q - CntW'(PayloadStart);
    len       = {len_hi_q, len_lo_q};
    exp_cnt   = 16'(FrameOverhead) + len;
    done      = (cnt_n >= CntW'(FrameOverhead)) && (16'(cnt_n) >= exp_cnt);
    full      = cnt_n == CntW'(StoreDepth);
    crc_take  = (cnt_q < CntW'(PayloadStart)) || (16'(off) < len);
    start_hit = have_q && ({prev_q, byte_i} == start_pattern_i);

    // checks in order: frame end reached (else overflow), length, crc, end word, handler bit
    if (!done) begin
      status = ST_OVERFLOW;
    end else if (len > 16'(MAX_PAYLOAD)) begin
      status = ST_LEN_BIG;
    end else if ({t2_q, t1_q} != crc_q) begin
      status = ST_CRC_BAD;
    end else if ({t0_q, byte_i} != end_pattern_i) begin
      status = ST_END_BAD;
    end else if (cmd_q >= 8'(CmdSlots) || !handler_mask_i[cmd_q[4:0]]) begin
      status = ST_NO_HANDLER;
    end else begin
      status = ST_DELIVERED;
    end

    in_frame_d  = in_frame_q;
    have_d      = have_q;
    cnt_d       = cnt_q;
    rpt_valid_o = 1'b0;
    if (byte_valid_i) begin
      if (!in_frame_q) begin
        if (start_hit) begin
          in_frame_d = 1'b1;
          have_d     = 1'b0;
          cnt_d      = CntW'(StartLen);
        end else begin
          have_d = 1'b1;
        end
      end else begin
        cnt_d = cnt_n;
        if (done || full) begin
          rpt_valid_o = 1'b1;
          in_frame_d  = 1'b0;
          cnt_d       = '0;
        end
      end
    end

    rpt_o.status  = status;
    rpt_o.src     = src_q;
    rpt_o.dst     = dst_q;
    rpt_o.cmd     = cmd_q;
    rpt_o.flags   = flags_q;
    rpt_o.plen    = len;
    rpt_o.deliver = status == ST_DELIVERED;

    wr_en_o   = byte_valid_i && in_frame_q && (cnt_q >= CntW'(PayloadStart))
                && (off < CntW'(MAX_PAYLOAD));
    wr_addr_o = off[AddrW-1:0];
    wr_data_o = byte_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      have_q     <= 1'b0;
      cnt_q      <= '0;
    end else begin
      in_frame_q <= in_frame_d;
      have_q     <= have_d;
      cnt_q      <= cnt_d;
    end
  end

  // header, tail window and crc
  always_ff @(posedge clk_i) begin
    if (byte_valid_i && !in_frame_q) begin
      prev_q <= byte_i;
      if (start_hit) begin
        crc_q <= CrcInit;
      end
    end
    if (byte_valid_i && in_frame_q) begin
      t0_q <= byte_i;
      t1_q <= t0_q;
      t2_q <= t1_q;
      if (crc_take) begin
        crc_q <= crc16_byte(crc_q, byte_i);
      end
      unique case (cnt_q)
        CntW'(2): src_q    <= byte_i;
        CntW'(3): dst_q    <= byte_i;
        CntW'(4): cmd_q    <= byte_i;
        CntW'(5): flags_q  <= byte_i;
        CntW'(6): len_hi_q <= byte_i;
        CntW'(7): len_lo_q <= byte_i;
        default: ;
      endcase
    end
  end

  `BSFR_ASSERT(a_rpt_in_frame, clk_i, rst_ni, rpt_valid_o |-> (in_frame_q && byte_valid_i))
  `BSFR_ASSERT(a_rpt_rehunt, clk_i, rst_ni, rpt_valid_o |=> (!in_frame_q && !have_q && cnt_q == '0))
  `BSFR_ASSERT(a_cnt_range, clk_i, rst_ni, in_frame_q |-> (cnt_q >= CntW'(StartLen) && cnt_q < CntW'(StoreDepth)))

endmodule

`default_nettype wire

[rtl/byte_stream_frame_receiver.sv]
// byte stream frame receiver: start hunt, crc16 check and payload delivery
//
// usage
// - slave side takes one received byte per word on s_axis_tdata_i
// - master side gives one result word per handshake: a status word for
//   every finished frame, or one word per payload byte (tuser set) for a
//   good frame whose command bit is enabled in handler_mask, tlast on the
//   final word of the frame
// - config writes through cfg_we_i / cfg_idx_i / cfg_data_i, only while idle
// throughput and ordering
// - bytes are taken one per cycle while no report is waiting
// - a status word passes through the report register into the output register
// - payload read-out goes through the payload ram, 1 read per byte: each byte
//   is read, then loaded once the output register is free, before the next read
// reset
// - hunting for the start word, registers at their defaults, no ram clear
// stalls
// - from the frame end, s_axis_tready_o stays low until the report and all
//   its payload words have moved into the output register; a word held in
//   the output register alone does not block input
`default_nettype none
`include "assert_macros.svh"

module byte_stream_frame_receiver import bsfr_pkg::*; #(
  parameter int unsigned MAX_PAYLOAD = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // rx_byte[7:0]
  input  wire logic [7:0]  s_axis_tdata_i,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // status[2:0], source_addr[10:3], dest_addr[18:11], command[26:19],
  // frame_flags[34:27], payload_length[50:35], data_byte[58:51], zero pad
  output logic [63:0]      m_axis_tdata_o,
  // data_valid[0]
  output logic [0:0]       m_axis_tuser_o,
  output logic             m_axis_tlast_o,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_data_i
);

  localparam int unsigned AddrW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  // read-out sequencer codes
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_LOAD = 2'd2;

  logic [15:0] start_pattern_q, end_pattern_q;
  logic [31:0] handler_mask_q;

  logic             in_acc;
  logic             wr_en;
  logic [AddrW-1:0] wr_addr;
  logic [7:0]       wr_data;
  logic             df_rpt_valid;
  rpt_t             df_rpt;

  logic             rpt_valid_q, rpt_valid_d;
  rpt_t             rpt_q;
  logic [1:0]       st_q, st_d;
  logic [AddrW-1:0] rd_idx_q, rd_idx_d;
  logic             rd_en;
  logic [7:0]       mem_q [MAX_PAYLOAD];
  logic [7:0]       mem_rdata_q;

  logic             out_valid_q, out_valid_d;
  logic             out_free, out_load;
  rpt_t             out_rpt_q;
  logic [7:0]       out_data_q, out_data_d;
  logic             out_dv_q, out_dv_d;
  logic             out_last_q, out_last_d;
  logic             rd_last;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_pattern_q <= StartPatternRst;
      end_pattern_q   <= EndPatternRst;
      handler_mask_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegStartPattern: start_pattern_q <= cfg_data_i[15:0];
        RegEndPattern:   end_pattern_q   <= cfg_data_i[15:0];
        RegHandlerMask:  handler_mask_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input is taken only while no report waits to be drained
  assign s_axis_tready_o = (st_q == S_IDLE) && !rpt_valid_q;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  bsfr_deframer #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_deframer (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .byte_valid_i   (in_acc),
    .byte_i         (s_axis_tdata_i),
    .start_pattern_i(start_pattern_q),
    .end_pattern_i  (end_pattern_q),
    .handler_mask_i (handler_mask_q),
    .wr_en_o        (wr_en),
    .wr_addr_o      (wr_addr),
    .wr_data_o      (wr_data),
    .rpt_valid_o    (df_rpt_valid),
    .rpt_o          (df_rpt)
  );

  // payload ram: writes only while input flows, reads only while a report
  // is drained, so the two never meet on one entry
  assign rd_en = st_q == S_READ;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_rdata_q <= mem_q[rd_idx_q];
    end
  end

  assign out_free = !out_valid_q || m_axis_tready_i;
  assign rd_last  = (16'(rd_idx_q) + 16'd1) == rpt_q.plen;

  always_comb begin
    st_d        = st_q;
    rd_idx_d    = rd_idx_q;
    rpt_valid_d = rpt_valid_q;
    out_load    = 1'b0;
    out_data_d  = 8'h00;
    out_dv_d    = 1'b0;
    out_last_d  = 1'b1;

    unique case (st_q)
      S_IDLE: begin
        if (rpt_valid_q && out_free) begin
          if (rpt_q.deliver && rpt_q.plen != 16'd0) begin
            st_d     = S_READ;
            rd_idx_d = '0;
          end else begin
            // single status word
            out_load    = 1'b1;
            rpt_valid_d = 1'b0;
          end
        end
      end
      S_READ: begin
        st_d = S_LOAD;
      end
      S_LOAD: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_data_d = mem_rdata_q;
          out_dv_d   = 1'b1;
          out_last_d = rd_last;
          if (rd_last) begin
            st_d        = S_IDLE;
            rpt_valid_d = 1'b0;
          end else begin
            st_d     = S_READ;
            rd_idx_d = rd_idx_q + 1'b1;
          end
        end
      end
      default: st_d = S_IDLE;
    endcase

    if (df_rpt_valid) begin
      rpt_valid_d = 1'b1;
    end

    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_IDLE;
      rpt_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
      rd_idx_q    <= '0;
    end else begin
      st_q        <= st_d;
      rpt_valid_q <= rpt_valid_d;
      out_valid_q <= out_valid_d;
      rd_idx_q    <= rd_idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (df_rpt_valid) begin
      rpt_q <= df_rpt;
    end
    if (out_load) begin
      out_rpt_q  <= rpt_q;
      out_data_q <= out_data_d;
      out_dv_q   <= out_dv_d;
      out_last_q <= out_last_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {5'd0, out_data_q, out_rpt_q.plen, out_rpt_q.flags,
                            out_rpt_q.cmd, out_rpt_q.dst, out_rpt_q.src,
                            out_rpt_q.status};
  assign m_axis_tuser_o  = out_dv_q;
  assign m_axis_tlast_o  = out_last_q;

  `BSFR_ASSERT_ALWAYS(a_no_rw_overlap, clk_i, !(wr_en && rd_en))
  `BSFR_ASSERT(a_busy_has_rpt, clk_i, rst_ni, (st_q != S_IDLE) |-> rpt_valid_q)
  `BSFR_ASSERT(a_status_is_last, clk_i, rst_ni, (out_valid_q && !out_dv_q) |-> out_last_q)
  `BSFR_ASSERT(a_rd_in_range, clk_i, rst_ni, (st_q != S_IDLE) |-> (16'(rd_idx_q) < rpt_q.plen))

endmodule

`default_nettype wire

[bench/tb_byte_stream_frame_receiver.sv]
// testbench for the byte stream frame receiver: framed byte traffic, predicted report words
`timescale 1ns / 100ps

module tb_byte_stream_frame_receiver;
  import bsfr_pkg::*;

  localparam int unsigned MaxPayload = 64;
  localparam int unsigned StoreDepth = FrameOverhead + MaxPayload;
  localparam int unsigned CycleLimit = 500_000;

  // one output word as the block should give it
  typedef struct {
    status_e     status;
    logic [7:0]  src;
    logic [7:0]  dst;
    logic [7:0]  cmd;
    logic [7:0]  flags;
    logic [15:0] plen;
    logic [7:0]  data;
    logic        valid;
    logic        last;
  } frame_word_t;

  // frame tracker: follows the byte stream and queues the words each frame should produce
  class frame_scoreboard;
    logic [15:0] start_word;
    logic [15:0] end_word;
    logic [31:0] cmd_mask;
    bit          in_frame;
    int unsigned held;
    logic [7:0]  store [StoreDepth];
    frame_word_t pending [$];
    int unsigned bytes_seen;
    int unsigned words_due;
    int unsigned mismatches;

    function new();
      start_word = StartPatternRst;
      end_word   = EndPatternRst;
      cmd_mask   = '0;
      in_frame   = 1'b0;
      held       = 0;
      bytes_seen = 0;
      words_due  = 0;
      mismatches = 0;
    endfunction

    // crc16 ccitt-false, msb first
    function logic [15:0] crc_ccitt(logic [7:0] octets [$]);
      logic [15:0] c;
      c = CrcInit;
      foreach (octets[i]) begin
        c ^= {octets[i], 8'h00};
        for (int j = 0; j < 8; j++) c = c[15] ? ((c << 1) ^ CrcPoly) : (c << 1);
      end
      return c;
    endfunction

    function void add_word(status_e st, logic [7:0] data, logic valid, logic last);
      frame_word_t w;
      w.status = st;
      w.src    = store[2];
      w.dst    = store[3];
      w.cmd    = store[4];
      w.flags  = store[5];
      w.plen   = {store[6], store[7]};
      w.data   = data;
      w.valid  = valid;
      w.last   = last;
      pending.push_back(w);
      words_due++;
    endfunction

    // checks in order: length, crc, end word, handler bit
    function void close_frame(int unsigned plen);
      logic [7:0] covered [$];
      logic [7:0] cmd;
      cmd = store[4];
      if (plen > MaxPayload) begin
        add_word(ST_LEN_BIG, 8'h00, 1'b0, 1'b1);
        return;
      end
      for (int i = 2; i < 8 + plen; i++) covered.push_back(store[i]);
      if ({store[8 + plen], store[9 + plen]} != crc_ccitt(covered))
        add_word(ST_CRC_BAD, 8'h00, 1'b0, 1'b1);
      else if ({store[10 + plen], store[11 + plen]} != end_word)
        add_word(ST_END_BAD, 8'h00, 1'b0, 1'b1);
      else if (cmd >= CmdSlots || !cmd_mask[cmd[4:0]])
        add_word(ST_NO_HANDLER, 8'h00, 1'b0, 1'b1);
      else if (plen == 0)
        add_word(ST_DELIVERED, 8'h00, 1'b0, 1'b1);
      else
        for (int i = 0; i < plen; i++)
          add_word(ST_DELIVERED, store[8 + i], 1'b1, (i + 1 == plen));
    endfunction

    function void note_byte(logic [7:0] b);
      int unsigned plen;
      int unsigned ends_at;
      bytes_seen++;
      if (!in_frame) begin
        // two-byte sliding window, older byte in the high half
        if (held > 1) held = 0;
        store[held] = b;
        held++;
        if (held >= 2) begin
          if ({store[0], store[1]} == start_word) in_frame = 1'b1;
          else begin
            store[0] = store[1];
            held = 1;
          end
        end
        return;
      end
      if (held < StoreDepth) store[held] = b;
      held++;
      if (held >= FrameOverhead) begin
        plen = {store[6], store[7]};
        // a length near the top wraps this sum and ends the frame at once
        ends_at = (FrameOverhead + plen) % 65536;
        if (held >= ends_at) begin
          close_frame(plen);
          held = 0;
          in_frame = 1'b0;
          return;
        end
      end
      if (held >= StoreDepth) begin
        add_word(ST_OVERFLOW, 8'h00, 1'b0, 1'b1);
        held = 0;
        in_frame = 1'b0;
      end
    endfunction

    function string show(frame_word_t w);
      return $sformatf("status %0d src %02h dst %02h cmd %02h flags %02h len %04h data %02h valid %b last %b",
                       w.status, w.src, w.dst, w.cmd, w.flags, w.plen, w.data, w.valid, w.last);
    endfunction

    function void check_word(frame_word_t got);
      frame_word_t want;
      if (pending.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected word: expected none, got %s", $time, show(got));
        return;
      end
      want = pending.pop_front();
      if (got.status !== want.status || got.src !== want.src || got.dst !== want.dst ||
          got.cmd !== want.cmd || got.flags !== want.flags || got.plen !== want.plen ||
          got.data !== want.data || got.valid !== want.valid || got.last !== want.last) begin
        mismatches++;
        $display("%0t: word mismatch: expected %s, got %s", $time, show(want), show(got));
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n = 1'b0;
  logic [7:0]  s_tdata = 8'h00;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] m_tdata;
  logic [0:0]  m_tuser;
  logic        m_tlast;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_idx = RegStartPattern;
  logic [31:0] cfg_data = '0;

  // idle chance per cycle, in percent, for the byte sender and the word receiver
  int unsigned tx_idle_pct = 7;
  int unsigned rx_idle_pct = 61;
  int unsigned cycle_count = 0;

  frame_scoreboard sb;

  byte_stream_frame_receiver #(
    .MAX_PAYLOAD(MaxPayload)
  ) dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .m_axis_tdata_o (m_tdata),
    .m_axis_tuser_o (m_tuser),
    .m_axis_tlast_o (m_tlast),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // hard stop in case the block hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("byte_stream_frame_receiver regression: fail");
      $finish;
    end
  end

  // receiver backpressure, one decision per cycle
  always @(negedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // unpack one output word: tdata fields from bit 0 up, data_valid in tuser
  function automatic frame_word_t decode_word(logic [63:0] d, logic v, logic l);
    frame_word_t w;
    w.status = status_e'(d[2:0]);
    w.src    = d[10:3];
    w.dst    = d[18:11];
    w.cmd    = d[26:19];
    w.flags  = d[34:27];
    w.plen   = d[50:35];
    w.data   = d[58:51];
    w.valid  = v;
    w.last   = l;
    return w;
  endfunction

  // both handshakes sampled at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (s_tvalid && s_tready) sb.note_byte(s_tdata);
      if (m_tvalid && m_tready) sb.check_word(decode_word(m_tdata, m_tuser[0], m_tlast));
    end
  end

  // called at a falling edge; returns at the falling edge after the word is taken,
  // with tvalid still high so back-to-back bytes need no second assignment
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tdata  <= b;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  // start word, header, payload, crc and end word under the current settings
  task automatic send_frame(input logic [7:0] src, input logic [7:0] dst,
                            input logic [7:0] cmd, input logic [7:0] flags,
                            input logic [15:0] len, input logic [15:0] crc_flip,
                            input logic [15:0] end_flip);
    logic [7:0]  body [$];
    logic [15:0] crc;
    logic [15:0] tail;
    int unsigned fill;
    body = {src, dst, cmd, flags, len[15:8], len[7:0]};
    // wrapping lengths end at the 12th byte; other oversized ones run into the store limit
    if (len <= MaxPayload) fill = len;
    else if (len >= 65536 - FrameOverhead) fill = 0;
    else fill = MaxPayload + 2;
    repeat (fill) body.push_back(8'($urandom_range(0, 255)));
    crc  = sb.crc_ccitt(body) ^ crc_flip;
    tail = sb.end_word ^ end_flip;
    send_byte(sb.start_word[15:8]);
    send_byte(sb.start_word[7:0]);
    foreach (body[i]) send_byte(body[i]);
    send_byte(crc[15:8]);
    send_byte(crc[7:0]);
    send_byte(tail[15:8]);
    send_byte(tail[7:0]);
  endtask

  // short frames only, so the random phases stay small
  task automatic send_random_frame();
    int unsigned pick;
    int unsigned len;
    logic [7:0]  cmd;
    logic [15:0] crc_flip;
    logic [15:0] end_flip;
    pick = $urandom_range(0, 99);
    if (pick < 70) len = $urandom_range(0, 6);
    else if (pick < 85) len = $urandom_range(7, 20);
    else len = $urandom_range(65536 - FrameOverhead, 65535);
    cmd = ($urandom_range(0, 99) < 80) ? 8'($urandom_range(0, CmdSlots - 1))
                                       : 8'($urandom_range(CmdSlots, 255));
    crc_flip = '0;
    end_flip = '0;
    pick = $urandom_range(0, 99);
    if (pick < 10) crc_flip = 16'($urandom_range(1, 65535));
    else if (pick < 20) end_flip = 16'($urandom_range(1, 65535));
    send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), cmd,
               8'($urandom_range(0, 255)), 16'(len), crc_flip, end_flip);
  endtask

  // mostly clean frames with random content, some noise between them
  task automatic run_random_phase();
    int unsigned bytes0;
    int unsigned words0;
    bytes0 = sb.bytes_seen;
    words0 = sb.words_due;
    while (sb.bytes_seen - bytes0 < 12 || sb.words_due - words0 < 3) begin
      if ($urandom_range(0, 99) < 8) begin
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
      end else begin
        if ($urandom_range(0, 1)) send_byte(8'($urandom_range(0, 255)));
        send_random_frame();
      end
    end
  endtask

  // finish any open frame with filler, then let every word drain
  task automatic settle();
    while (sb.in_frame) send_byte(8'($urandom_range(0, 255)));
    s_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    // hunting bytes leave nothing to wait on, so the pipeline is given spare idle cycles as well
    repeat (12) @(negedge clk);
  endtask

  // all three registers, one per cycle, only while idle
  task automatic program_regs(input logic [15:0] start_w, input logic [15:0] end_w,
                              input logic [31:0] mask);
    logic [15:0] junk;
    junk = 16'($urandom_range(0, 65535));
    cfg_we   <= 1'b1;
    cfg_idx  <= RegStartPattern;
    cfg_data <= {junk, start_w};
    @(negedge clk);
    cfg_idx  <= RegEndPattern;
    cfg_data <= {~junk, end_w};
    @(negedge clk);
    cfg_idx  <= RegHandlerMask;
    cfg_data <= mask;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.start_word = start_w;
    sb.end_word   = end_w;
    sb.cmd_mask   = mask;
  endtask

  initial begin
    sb = new();
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings: mask clear, so a clean frame has no handler;
    // the extra leading start byte makes the window slide once
    send_byte(StartPatternRst[15:8]);
    send_frame(8'h01, 8'h02, 8'h00, 8'h00, 16'd0, 16'h0000, 16'h0000);
    settle();
    program_regs(StartPatternRst, EndPatternRst, 32'hFFFF_FFFF);
    // header extremes, single byte and empty deliveries
    send_frame(8'hFF, 8'h00, 8'd31, 8'hFF, 16'd1, 16'h0000, 16'h0000);
    send_frame(8'h00, 8'hFF, 8'd0, 8'h00, 16'd0, 16'h0000, 16'h0000);
    // command past the handler slots
    send_frame(8'h10, 8'h20, 8'd32, 8'h5A, 16'd0, 16'h0000, 16'h0000);
    // wrapping length, then a length that runs into the store limit
    send_frame(8'h33, 8'h44, 8'd5, 8'h00, 16'hFFFF, 16'h0000, 16'h0000);
    send_frame(8'h55, 8'h66, 8'd7, 8'h01, 16'd65, 16'h0000, 16'h0000);
    // bad crc, bad end word, full payload
    send_frame(8'h77, 8'h88, 8'd9, 8'h02, 16'd0, 16'h0001, 16'h0000);
    send_frame(8'h77, 8'h88, 8'd9, 8'h02, 16'd0, 16'h0000, 16'h8000);
    send_frame(8'h99, 8'hAA, 8'd30, 8'h80, 16'(MaxPayload), 16'h0000, 16'h0000);
    settle();

    // sender rarely idle, receiver mostly stalled
    program_regs(16'h0000, 16'hFFFF, $urandom);
    run_random_phase();
    settle();

    // roles swapped
    tx_idle_pct = 61;
    rx_idle_pct = 7;
    program_regs(16'hFFFF, 16'h0000, $urandom);
    run_random_phase();
    settle();

    // full rate on both sides
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    program_regs(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)), $urandom);
    run_random_phase();
    settle();

    if (sb.mismatches == 0 && sb.pending.size() == 0)
      $display("byte_stream_frame_receiver regression: pass");
    else
      $display("byte_stream_frame_receiver regression: fail");
    $finish;
  end

endmodule
